// ===== sv/spe_pkg.sv =====
// ----------------------------------------------------------------------------
// spe_pkg
// Shared types and constants for the sparse polynomial evaluator.
// ----------------------------------------------------------------------------
package spe_pkg;

	localparam int MAX_TERMS    = 64;
	localparam int MAX_EXPONENT = 63;

	localparam int COEF_W = 32;
	localparam int EXP_W  = 6;
	localparam int X_W    = 32;
	localparam int SUM_W  = 64;
	localparam int TU_W   = 7;

	localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int CNT_W = $clog2(MAX_TERMS + 1);
	localparam int BIT_W = (EXP_W > 1) ? $clog2(EXP_W) : 1;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_EVAL = 1'b1;

	typedef logic [COEF_W-1:0] coef_t;
	typedef logic [EXP_W-1:0]  exp_t;
	typedef logic [SUM_W-1:0]  sum_t;
	typedef logic [TU_W-1:0]   terms_used_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [BIT_W-1:0]  bit_idx_t;

	typedef struct packed {
		coef_t coef;
		exp_t  exponent;
	} term_t;

	typedef enum logic [1:0] {
		MUL_ONE,
		MUL_SQR,
		MUL_OPND
	} mul_op_t;

	typedef struct packed {
		logic    en;
		mul_op_t op;
	} mul_ctrl_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_SQR,
		S_MULX,
		S_MULC,
		S_ACC,
		S_DONE
	} state_t;

endpackage

// ===== sv/spe_mul_unit.sv =====
// ----------------------------------------------------------------------------
// spe_mul_unit
// Shared 32-bit wrapping multiplier with its own accumulator register.
// ----------------------------------------------------------------------------
module spe_mul_unit (
	input  logic                clk,
	input  spe_pkg::mul_ctrl_t  ctrl,
	input  spe_pkg::coef_t      operand,
	output spe_pkg::coef_t      acc
);

	spe_pkg::coef_t                      acc_q;
	spe_pkg::coef_t                      rhs;
	logic [2*spe_pkg::COEF_W-1:0]        prod;

	always_comb begin
		case (ctrl.op)
			spe_pkg::MUL_SQR:  rhs = acc_q;
			spe_pkg::MUL_OPND: rhs = operand;
			default:           rhs = acc_q;
		endcase
		prod = acc_q * rhs;
	end

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			case (ctrl.op)
				spe_pkg::MUL_ONE: acc_q <= spe_pkg::coef_t'(1);
				default:          acc_q <= prod[spe_pkg::COEF_W-1:0];
			endcase
		end
	end

	assign acc = acc_q;

endmodule

// ===== sv/sparse_polynomial_evaluator_core.sv =====
// ----------------------------------------------------------------------------
// sparse_polynomial_evaluator_core
// Stores polynomial terms and evaluates their sum at a point on request.
// ----------------------------------------------------------------------------
// Channel  Handshake              Payload
// req      req_valid / req_ready  req_type, term_coef, term_exponent, point_x
// rsp      rsp_valid / rsp_ready  poly_value, terms_used, terms_dropped
//
// A load returns nothing. An evaluation handles the stored terms one by one,
// paced by the single shared 32-bit multiplier that squares, multiplies by x
// and multiplies by the coefficient in turn.
// The request side is not ready from an evaluate transfer until its result
// transfer completes. Reset empties the term store and clears the flag.
// ----------------------------------------------------------------------------
module sparse_polynomial_evaluator_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic                        req_type,
	input  logic signed [31:0]          term_coef,
	input  logic [5:0]                  term_exponent,
	input  logic signed [31:0]          point_x,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output logic signed [63:0]          poly_value,
	output logic [6:0]                  terms_used,
	output logic                        terms_dropped
);

	spe_pkg::state_t     state_q, state_d;
	spe_pkg::cnt_t       cnt_q;
	logic                ovf_q;
	spe_pkg::idx_t       idx_q;
	spe_pkg::bit_idx_t   bit_q;
	spe_pkg::coef_t      x_q;
	spe_pkg::sum_t       sum_q;
	spe_pkg::term_t      rd_q;
	spe_pkg::term_t      mem [spe_pkg::MAX_TERMS];

	spe_pkg::mul_ctrl_t  mul_ctrl;
	spe_pkg::coef_t      mul_opnd;
	spe_pkg::coef_t      mul_acc;
	spe_pkg::exp_t       exp_sat;
	logic                req_xfer;
	logic                rsp_xfer;
	logic                store_full;
	logic                last_term;
	logic                wr_en;
	logic                rd_en;

	assign req_xfer   = req_valid && req_ready;
	assign rsp_xfer   = rsp_valid && rsp_ready;
	assign store_full = !(cnt_q < spe_pkg::cnt_t'(spe_pkg::MAX_TERMS));
	assign last_term  = (spe_pkg::cnt_t'(idx_q) + spe_pkg::cnt_t'(1)) == cnt_q;
	assign exp_sat    = (term_exponent > spe_pkg::exp_t'(spe_pkg::MAX_EXPONENT)) ?
		spe_pkg::exp_t'(spe_pkg::MAX_EXPONENT) : term_exponent;
	assign wr_en      = req_xfer && (req_type == spe_pkg::REQ_LOAD) && !store_full;
	assign mul_opnd   = (state_q == spe_pkg::S_MULC) ? rd_q.coef : x_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spe_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		req_ready   = 1'b0;
		rsp_valid   = 1'b0;
		rd_en       = 1'b0;
		mul_ctrl.en = 1'b0;
		mul_ctrl.op = spe_pkg::MUL_ONE;
		case (state_q)
			spe_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_xfer && (req_type == spe_pkg::REQ_EVAL)) begin
					state_d = (cnt_q == '0) ? spe_pkg::S_DONE : spe_pkg::S_READ;
				end
			end
			spe_pkg::S_READ: begin
				rd_en       = 1'b1;
				mul_ctrl.en = 1'b1;
				mul_ctrl.op = spe_pkg::MUL_ONE;
				state_d     = spe_pkg::S_SQR;
			end
			spe_pkg::S_SQR: begin
				mul_ctrl.en = 1'b1;
				mul_ctrl.op = spe_pkg::MUL_SQR;
				if (rd_q.exponent[bit_q]) begin
					state_d = spe_pkg::S_MULX;
				end else if (bit_q == '0) begin
					state_d = spe_pkg::S_MULC;
				end
			end
			spe_pkg::S_MULX: begin
				mul_ctrl.en = 1'b1;
				mul_ctrl.op = spe_pkg::MUL_OPND;
				state_d     = (bit_q == '0) ? spe_pkg::S_MULC : spe_pkg::S_SQR;
			end
			spe_pkg::S_MULC: begin
				mul_ctrl.en = 1'b1;
				mul_ctrl.op = spe_pkg::MUL_OPND;
				state_d     = spe_pkg::S_ACC;
			end
			spe_pkg::S_ACC: begin
				state_d = last_term ? spe_pkg::S_DONE : spe_pkg::S_READ;
			end
			spe_pkg::S_DONE: begin
				rsp_valid = 1'b1;
				if (rsp_ready) begin
					state_d = spe_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = spe_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (rsp_xfer) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (req_xfer && (req_type == spe_pkg::REQ_LOAD)) begin
			if (store_full) begin
				ovf_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q + spe_pkg::cnt_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer && (req_type == spe_pkg::REQ_EVAL)) begin
			x_q   <= point_x;
			sum_q <= '0;
			idx_q <= '0;
		end
		if (state_q == spe_pkg::S_READ) begin
			bit_q <= spe_pkg::bit_idx_t'(spe_pkg::EXP_W - 1);
		end
		if ((state_q == spe_pkg::S_SQR) && !rd_q.exponent[bit_q] && (bit_q != '0)) begin
			bit_q <= bit_q - spe_pkg::bit_idx_t'(1);
		end
		if ((state_q == spe_pkg::S_MULX) && (bit_q != '0)) begin
			bit_q <= bit_q - spe_pkg::bit_idx_t'(1);
		end
		if (state_q == spe_pkg::S_ACC) begin
			sum_q <= sum_q + spe_pkg::sum_t'($signed(mul_acc));
			if (!last_term) begin
				idx_q <= idx_q + spe_pkg::idx_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cnt_q[spe_pkg::IDX_W-1:0]] <= '{coef: term_coef, exponent: exp_sat};
		end
		if (rd_en) begin
			rd_q <= mem[idx_q];
		end
	end

	spe_mul_unit u_mul (
		.clk     (clk),
		.ctrl    (mul_ctrl),
		.operand (mul_opnd),
		.acc     (mul_acc)
	);

	assign poly_value    = sum_q;
	assign terms_used    = spe_pkg::terms_used_t'(cnt_q);
	assign terms_dropped = ovf_q;

endmodule
